>>> src/nvps_pkg.sv
// Shared types, constants and the BCD helper for the phantom-clock NVRAM.
package nvps_pkg;

   localparam int unsigned STORE_BYTES_DEF = 32768;

   localparam int unsigned ADDR_W   = 15;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [ADDR_W-1:0] CLOCK_PORT     = 15'd3;
   localparam logic [63:0]       UNLOCK_PATTERN = 64'h5ca3_3ac5_5ca3_3ac5;

   // action codes carried in req_tuser
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [2:0] weekday;
      logic [4:0] day_of_month;
      logic [3:0] month;
      logic [6:0] year;
   } now_type;

   // clock port transaction from top to the clock unit
   typedef struct packed {
      logic    fire;
      logic    write;
      logic    din;
      now_type now;
   } clk_req_type;

   typedef struct packed {
      logic rd_bit;
      logic unlocked;
   } clk_rsp_type;

   // binary (0..127) to two BCD digits, value taken modulo 100 first
   function automatic logic [7:0] bin2bcd(input logic [6:0] v);
      logic [6:0]  v100;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      v100     = (v >= 7'd100) ? v - 7'd100 : v;
      prod     = 15'(v100) * 15'd205;  // x*205 >> 11 == x/10 for x < 1029
      tens     = prod[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = v100 - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage

>>> src/nvps_store.sv
// Byte store: single-port synchronous RAM with registered read data.
module nvps_store #(
   parameter int unsigned STORE_BYTES = nvps_pkg::STORE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic                           we,
   input  logic [$clog2(STORE_BYTES)-1:0] idx,
   input  logic [7:0]                     wdata,
   output logic [7:0]                     rdata
);
   import nvps_pkg::*;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[idx] <= wdata;
         end
         rdata_ff <= mem[idx];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/nvps_clock.sv
// Hidden clock port: unlock shifter, pattern match and BCD time shifter.
module nvps_clock (
   input  logic                  clock,
   input  logic                  reset,
   input  nvps_pkg::clk_req_type req,
   output nvps_pkg::clk_rsp_type rsp
);
   import nvps_pkg::*;

   logic [63:0] unlock_ff, unlock_in;
   logic [63:0] time_ff, time_in;
   logic [63:0] now_bcd;
   logic        match;

   assign now_bcd = {bin2bcd(req.now.year),
                     bin2bcd(7'(req.now.month)),
                     bin2bcd(7'(req.now.day_of_month)),
                     bin2bcd(7'(req.now.weekday)),
                     bin2bcd(7'(req.now.hours)),
                     bin2bcd(7'(req.now.minutes)),
                     bin2bcd(7'(req.now.seconds)),
                     8'h00};

   always_comb begin
      unlock_in = unlock_ff;
      time_in   = time_ff;
      match     = 1'b0;
      if (req.fire) begin
         if (req.write) begin
            unlock_in = {req.din, unlock_ff[63:1]};
            match     = (unlock_in == UNLOCK_PATTERN);
            if (match) begin
               time_in = now_bcd;
            end
         end else begin
            time_in = {1'b0, time_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_ff <= '0;
         time_ff   <= '0;
      end else begin
         unlock_ff <= unlock_in;
         time_ff   <= time_in;
      end
   end

   assign rsp.rd_bit   = req.fire & ~req.write & time_ff[0];
   assign rsp.unlocked = match;

endmodule

>>> src/nvps_rsp_stage.sv
// Output register stage: holds one response and sets the request-side ready.
module nvps_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  from_mem,
   input  nvps_pkg::clk_rsp_type clk_rsp,
   input  logic [7:0]            mem_rdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  slot_free,
   output logic [7:0]            read_data,
   output logic                  clock_unlocked
);
   import nvps_pkg::*;

   logic        valid_ff, valid_in;
   logic        from_mem_ff;
   clk_rsp_type clk_ff;

   assign slot_free = ~valid_ff | rsp_tready;
   assign valid_in  = req_fire | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         from_mem_ff <= from_mem;
         clk_ff      <= clk_rsp;
      end
   end

   // RAM read data is only refreshed on acceptance, so it holds under stall
   assign rsp_tvalid     = valid_ff;
   assign read_data      = from_mem_ff ? mem_rdata : {7'd0, clk_ff.rd_bit};
   assign clock_unlocked = clk_ff.unlocked;

endmodule

>>> src/nvram_with_phantom_clock_port_core.sv
// Top level of the byte-wide NVRAM with hidden serial clock port.
//
// Request channel (req_*): one bus access per transaction. req_tuser is the
// action (0 read, 1 write); req_tdata carries address, write byte and the
// current time in binary. Address 3 is the clock port: writes shift bit 0
// into the unlock register, a completed unlock pattern loads the BCD time,
// reads return the time register's low bit in bit 0 and shift it out.
// Response channel (rsp_*): exactly one transaction per request, in order,
// with the read byte (0 on writes) and the unlock flag.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one transaction per cycle, set by the single RAM port and the
// one-entry output register; a request is taken whenever that register is
// empty or being drained in the same cycle.
// When the receiver stalls, the response holds and req_tready stays low
// until it drains.
// Reset clears the unlock and time registers and the response stage; the
// byte store keeps its contents and needs no clearing pass.
module nvram_with_phantom_clock_port_core #(
   parameter int unsigned STORE_BYTES = nvps_pkg::STORE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [14:0] address, [22:15] write_data, [28:23] now_seconds,
   // [34:29] now_minutes, [39:35] now_hours, [42:40] now_weekday,
   // [47:43] now_day_of_month, [51:48] now_month, [58:52] now_year, rest 0
   input  logic [nvps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] read_data, [8] clock_unlocked, rest 0
   output logic [nvps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import nvps_pkg::*;

   localparam int unsigned IDX_W = $clog2(STORE_BYTES);

   logic              fire;
   logic              slot_free;
   logic [ADDR_W-1:0] address;
   logic [7:0]        write_data;
   logic              is_write;
   logic              is_port;
   logic              in_range;
   logic [IDX_W-1:0]  idx;
   logic [7:0]        mem_rdata;
   logic [7:0]        read_data;
   logic              clock_unlocked;
   clk_req_type       clk_req;
   clk_rsp_type       clk_rsp;

   assign req_tready = slot_free;
   assign fire       = req_tvalid & slot_free;

   assign address    = req_tdata[14:0];
   assign write_data = req_tdata[22:15];
   assign is_write   = (req_tuser == ACT_WRITE);
   assign is_port    = (address == CLOCK_PORT);
   assign in_range   = (32'(address) < 32'(STORE_BYTES)) & ~is_port;
   assign idx        = IDX_W'(address);

   assign clk_req.fire             = fire & is_port;
   assign clk_req.write            = is_write;
   assign clk_req.din              = write_data[0];
   assign clk_req.now.seconds      = req_tdata[28:23];
   assign clk_req.now.minutes      = req_tdata[34:29];
   assign clk_req.now.hours        = req_tdata[39:35];
   assign clk_req.now.weekday      = req_tdata[42:40];
   assign clk_req.now.day_of_month = req_tdata[47:43];
   assign clk_req.now.month        = req_tdata[51:48];
   assign clk_req.now.year         = req_tdata[58:52];

   nvps_store #(
      .STORE_BYTES(STORE_BYTES)
   ) u_store (
      .clock (clock),
      .en    (fire),
      .we    (is_write & in_range),
      .idx   (idx),
      .wdata (write_data),
      .rdata (mem_rdata)
   );

   nvps_clock u_clock (
      .clock (clock),
      .reset (reset),
      .req   (clk_req),
      .rsp   (clk_rsp)
   );

   nvps_rsp_stage u_rsp (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (fire),
      .from_mem       (~is_write & in_range),
      .clk_rsp        (clk_rsp),
      .mem_rdata      (mem_rdata),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .slot_free      (slot_free),
      .read_data      (read_data),
      .clock_unlocked (clock_unlocked)
   );

   assign rsp_tdata = {7'd0, clock_unlocked, read_data};

`ifndef NO_ASSERTIONS
   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("accepted transaction produced no response");

   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response is stalled");

   a_unlock_on_write : assert property (@(posedge clock) disable iff (reset)
      fire && clk_rsp.unlocked |-> is_write && is_port)
      else $error("unlock flagged outside a clock-port write");

   a_unlock_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && clock_unlocked |-> read_data == 8'd0)
      else $error("unlock response carries read data");
`endif

endmodule

>>> bench/nvram_with_phantom_clock_port_core_tb.sv
// Self-checking bench for the phantom-clock NVRAM: store accesses, unlock sequences, clock reads.
`timescale 1ns / 1ps

module nvram_with_phantom_clock_port_core_tb;
   import nvps_pkg::*;

   localparam int unsigned MEM_BYTES    = STORE_BYTES_DEF;
   localparam int unsigned ITEM_TARGET  = 600;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam longint     RUN_LIMIT_NS = 10_000_000;

   typedef struct {
      logic [7:0] read_data;
      logic       unlocked;
   } nvram_reply_type;

   // Tracks the NVRAM contents and the clock port registers, and matches replies in order.
   class nvram_scoreboard_type;
      bit [7:0]        mem_image [MEM_BYTES];
      bit              written [MEM_BYTES];
      int unsigned     written_addrs[$];
      bit [63:0]       unlock_sr;
      bit [63:0]       time_sr;
      nvram_reply_type pending_replies[$];
      int unsigned     errors;

      function new();
         unlock_sr = '0;
         time_sr   = '0;
         errors    = 0;
      endfunction

      function bit [7:0] to_bcd(int unsigned v);
         int unsigned m;
         m = v % 100;
         return 8'(((m / 10) << 4) | (m % 10));
      endfunction

      function bit [63:0] time_image(now_type t);
         return {to_bcd(t.year), to_bcd(t.month), to_bcd(t.day_of_month), to_bcd(t.weekday),
                 to_bcd(t.hours), to_bcd(t.minutes), to_bcd(t.seconds), 8'h00};
      endfunction

      function void note_access(logic act, logic [14:0] addr, logic [7:0] wd, now_type t);
         nvram_reply_type r;
         r.read_data = 8'h00;
         r.unlocked  = 1'b0;
         if (addr == CLOCK_PORT) begin
            if (act == ACT_WRITE) begin
               unlock_sr = {wd[0], unlock_sr[63:1]};
               if (unlock_sr == UNLOCK_PATTERN) begin
                  time_sr    = time_image(t);
                  r.unlocked = 1'b1;
               end
            end else begin
               r.read_data = {7'b0, time_sr[0]};
               time_sr     = time_sr >> 1;
            end
         end else if (addr < MEM_BYTES) begin
            if (act == ACT_WRITE) begin
               mem_image[addr] = wd;
               if (!written[addr]) begin
                  written[addr] = 1'b1;
                  written_addrs.push_back(addr);
               end
            end else begin
               r.read_data = mem_image[addr];
            end
         end
         pending_replies.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      task check_reply(logic [RSP_DATA_W-1:0] d);
         nvram_reply_type e;
         if (pending_replies.size() == 0) begin
            report($sformatf("reply %h with nothing outstanding", d));
         end else begin
            e = pending_replies.pop_front();
            if (d[7:0] !== e.read_data)
               report($sformatf("read_data %h, expected %h", d[7:0], e.read_data));
            if (d[8] !== e.unlocked)
               report($sformatf("clock_unlocked %b, expected %b", d[8], e.unlocked));
         end
      endtask

      function int unsigned pending();
         return pending_replies.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = ACT_READ;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   nvram_scoreboard_type sb = new();
   int unsigned          items_sent = 0;
   bit                   steady = 1'b0;
   bit                   hold_off_req = 1'b0;

   nvram_with_phantom_clock_port_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

   // Both channels are sampled here, before any register update of this edge.
   always @(posedge clock) begin
      now_type t;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            t.seconds      = req_tdata[28:23];
            t.minutes      = req_tdata[34:29];
            t.hours        = req_tdata[39:35];
            t.weekday      = req_tdata[42:40];
            t.day_of_month = req_tdata[47:43];
            t.month        = req_tdata[51:48];
            t.year         = req_tdata[58:52];
            sb.note_access(req_tuser, req_tdata[14:0], req_tdata[22:15], t);
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_reply(rsp_tdata);
      end
   end

   // Receiver: random ready/stall runs, a long hold when asked, always ready in steady stretches.
   initial begin
      int roll;
      int n;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               rsp_tready <= 1'b1;
               n = $urandom_range(1, 20);
            end else if (roll < 90) begin
               rsp_tready <= 1'b0;
               n = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               n = $urandom_range(10, 40);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   function automatic now_type random_now();
      now_type t;
      t.seconds      = 6'($urandom_range(0, 63));
      t.minutes      = 6'($urandom_range(0, 63));
      t.hours        = 5'($urandom_range(0, 31));
      t.weekday      = 3'($urandom_range(0, 7));
      t.day_of_month = 5'($urandom_range(0, 31));
      t.month        = 4'($urandom_range(0, 15));
      t.year         = 7'($urandom_range(0, 127));
      return t;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(logic [14:0] addr, logic [7:0] wd,
                                                          now_type t);
      return {5'b0, t.year, t.month, t.day_of_month, t.weekday, t.hours, t.minutes,
              t.seconds, wd, addr};
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic drive_access(input logic act, input logic [14:0] addr, input logic [7:0] wd,
                               input now_type t);
      req_tuser  <= act;
      req_tdata  <= pack_request(addr, wd, t);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic sender_gap();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      n = 0;
      if (!steady) begin
         if (roll >= 92)
            n = $urandom_range(5, 40);
         else if (roll >= 70)
            n = $urandom_range(1, 3);
      end
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic access(input logic act, input logic [14:0] addr, input logic [7:0] wd);
      sender_gap();
      drive_access(act, addr, wd, random_now());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Shifts the unlock pattern in, LSB first; flip_at < 64 corrupts one bit,
   // extra writes keep following the pattern (it repeats every 32 bits).
   task automatic unlock_clock(input now_type t, input int flip_at, input int extra);
      logic b;
      for (int i = 0; i < 64 + extra; i++) begin
         b = UNLOCK_PATTERN[i % 64] ^ (i == flip_at);
         sender_gap();
         drive_access(ACT_WRITE, CLOCK_PORT, {7'($urandom_range(0, 127)), b}, t);
      end
   endtask

   task automatic read_clock(input int n);
      for (int i = 0; i < n; i++)
         access(ACT_READ, CLOCK_PORT, 8'($urandom_range(0, 255)));
   endtask

   task automatic store_burst(input int n);
      logic [14:0] addr;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0 || sb.written_addrs.size() == 0) begin
            do addr = 15'($urandom_range(0, MEM_BYTES - 1)); while (addr == CLOCK_PORT);
            access(ACT_WRITE, addr, 8'($urandom_range(0, 255)));
         end else begin
            addr = 15'(sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)]);
            access(ACT_READ, addr, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      now_type t_max;
      now_type t_zero;
      int roll;
      t_max  = '{6'd63, 6'd63, 5'd31, 3'd7, 5'd31, 4'd15, 7'd127};
      t_zero = '{default: '0};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: clock port before any unlock, store extremes, neighbors of the port
      access(ACT_READ, CLOCK_PORT, 8'h00);
      access(ACT_READ, CLOCK_PORT, 8'hFF);
      access(ACT_WRITE, 15'd0, 8'h00);
      access(ACT_WRITE, 15'h7FFF, 8'hFF);
      access(ACT_WRITE, 15'd2, 8'hA5);
      access(ACT_WRITE, 15'd4, 8'h5A);
      access(ACT_WRITE, CLOCK_PORT, 8'hFE);
      access(ACT_WRITE, CLOCK_PORT, 8'h01);
      access(ACT_READ, 15'd0, 8'h00);
      access(ACT_READ, 15'h7FFF, 8'h00);
      access(ACT_READ, 15'd2, 8'h00);
      access(ACT_READ, 15'd4, 8'h00);
      access(ACT_WRITE, 15'd0, 8'hFF);
      access(ACT_WRITE, 15'h7FFF, 8'h00);
      access(ACT_READ, 15'd0, 8'h00);
      access(ACT_READ, 15'h7FFF, 8'h00);
      access(ACT_READ, CLOCK_PORT, 8'h00);
      wait_drained();

      // out-of-range time fields, then read the time register past empty
      unlock_clock(t_max, 64, 0);
      read_clock(70);
      // zero time, with steady traffic on both sides
      steady = 1'b1;
      unlock_clock(t_zero, 64, 0);
      read_clock(66);
      steady = 1'b0;

      // receiver holds off while requests keep coming
      hold_off_req = 1'b1;
      store_burst(30);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            unlock_clock(random_now(), 64, ($urandom_range(0, 3) == 0) ? 32 : 0);
            read_clock($urandom_range(8, 70));
         end else if (roll < 22) begin
            unlock_clock(random_now(), $urandom_range(0, 63), 0);
            read_clock($urandom_range(2, 10));
         end else if (roll < 75) begin
            store_burst($urandom_range(5, 20));
         end else if (roll < 85) begin
            for (int i = 0; i < 8; i++)
               access(1'($urandom_range(0, 1)), CLOCK_PORT, 8'($urandom_range(0, 255)));
         end else if (roll < 92) begin
            steady = 1'b1;
            store_burst($urandom_range(10, 30));
            steady = 1'b0;
         end else if (roll < 96) begin
            hold_off_req = 1'b1;
            store_burst(12);
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d replies never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> nvram_with_phantom_clock_port_core.f
src/nvps_pkg.sv
src/nvps_store.sv
src/nvps_clock.sv
src/nvps_rsp_stage.sv
src/nvram_with_phantom_clock_port_core.sv
bench/nvram_with_phantom_clock_port_core_tb.sv
